// File: hdl/dmct_pkg.sv
// types, constants and the state machine encoding for the direct-mapped cache tracker
// no dependencies: imported by dmct_stats and direct_mapped_cache_tracker
`timescale 1ns / 1ps

package dmct_pkg;

  // default geometry
  localparam int INDEX_BITS_DEF   = 12;
  localparam int OFFSET_BITS_DEF  = 2;
  localparam int ADDRESS_BITS_DEF = 32;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic REG_WRITE_BACK_MODE = 1'b0;

  // request type code
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
  } dmct_req_t;

  typedef struct packed {
    logic        hit;
    logic        line_fetch;
    logic        memory_write;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] fetch_count;
    logic [31:0] store_count;
  } dmct_rsp_t;

  // event that updates the counters
  typedef struct packed {
    logic en;
    logic hit;
    logic mem_write;
  } dmct_stat_upd_t;

  typedef struct packed {
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] fetches;
    logic [31:0] stores;
  } dmct_stat_cnt_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } dmct_state_t;

endpackage

// File: hdl/dmct_ram.sv
// generic single-port synchronous ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module dmct_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/dmct_stats.sv
// saturating hit, miss, fetch and store counters of the cache tracker
// depends on dmct_pkg for the update and count structs
`timescale 1ns / 1ps

module dmct_stats
  import dmct_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dmct_stat_upd_t upd,
  output dmct_stat_cnt_t cnt_nxt
);

  dmct_stat_cnt_t cnt_r;

  function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic inc);
    sat_inc = (inc && (v != '1)) ? v + 32'd1 : v;
  endfunction

  // next values, also handed to the output register
  always_comb begin
    cnt_nxt         = cnt_r;
    cnt_nxt.hits    = sat_inc(cnt_r.hits, upd.hit);
    cnt_nxt.misses  = sat_inc(cnt_r.misses, !upd.hit);
    cnt_nxt.fetches = sat_inc(cnt_r.fetches, !upd.hit);
    cnt_nxt.stores  = sat_inc(cnt_r.stores, upd.mem_write);
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (upd.en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/direct_mapped_cache_tracker.sv
// direct-mapped write-allocate cache tag tracker: line state in one ram, read-modify-write
// result: the item is put in the output register as the lookup finishes; a stalled full output slot holds the lookup
// requests: a new one is taken only after the last has written back, set by the single ram port (read, then write back)
// reset: synchronous; a clearing pass over all 2**INDEX_BITS lines (4096 by default) zeroes
// valid and dirty of every line while in_stall stays high; configuration is taken throughout
// depends on dmct_pkg, dmct_ram and dmct_stats
`timescale 1ns / 1ps

module direct_mapped_cache_tracker
  import dmct_pkg::*;
#(
  parameter int INDEX_BITS   = INDEX_BITS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  dmct_req_t                in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output dmct_rsp_t                out_data,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int EFF_BITS   = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;
  localparam int TAG_SHIFT  = OFFSET_BITS + INDEX_BITS;
  localparam int TAG_BITS   = (EFF_BITS > TAG_SHIFT) ? EFF_BITS - TAG_SHIFT : 1;
  localparam int LINE_BITS  = TAG_BITS + 2;
  localparam int NUM_LINES  = 1 << INDEX_BITS;
  localparam logic [31:0] ADDR_MASK =
    (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

  dmct_state_t state_r, state_nxt;

  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [INDEX_BITS-1:0] req_idx_r;
  logic [TAG_BITS-1:0]   req_tag_r;
  logic                  req_write_r;
  logic                  mode_r;

  logic                  out_valid_r, out_valid_nxt;
  dmct_rsp_t             out_data_r;

  logic [31:0]           addr_m;
  logic [INDEX_BITS-1:0] in_idx;
  logic [TAG_BITS-1:0]   in_tag;
  logic                  in_acc;
  logic                  done;

  logic                  ram_we, ram_re;
  logic [INDEX_BITS-1:0] ram_addr;
  logic [LINE_BITS-1:0]  ram_wdata, ram_rdata;

  logic                  old_valid, old_dirty, hit, wr_wb, mem_write, new_dirty;
  logic [TAG_BITS-1:0]   old_tag;

  dmct_stat_upd_t        upd;
  dmct_stat_cnt_t        cnt_nxt;

  // configuration register, reads are combinational
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_WRITE_BACK_MODE) begin
      mode_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WRITE_BACK_MODE) begin
      prdata[0] = mode_r;
    end
  end

  // address split, excess high bits masked off
  assign addr_m = in_data.address & ADDR_MASK;
  assign in_idx = INDEX_BITS'(addr_m >> OFFSET_BITS);
  assign in_tag = TAG_BITS'(addr_m >> TAG_SHIFT);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // request hold registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_idx_r   <= in_idx;
      req_tag_r   <= in_tag;
      req_write_r <= (in_data.req_type == REQ_WRITE);
    end
  end

  // line lookup and update
  assign {old_valid, old_dirty, old_tag} = ram_rdata;
  assign hit       = old_valid && (old_tag == req_tag_r);
  assign wr_wb     = req_write_r && mode_r;
  assign new_dirty = hit ? (old_dirty | wr_wb) : wr_wb;
  assign mem_write = (req_write_r && !mode_r) || (!hit && mode_r && old_dirty);
  assign done      = (state_r == ST_LOOKUP) && (!out_valid_r || !out_stall);

  // sequencer: clearing pass, idle, lookup with write back
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = in_idx;
    ram_wdata   = {1'b1, new_dirty, req_tag_r};
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == {INDEX_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_re = in_valid;
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        ram_addr = req_idx_r;
        if (done) begin
          ram_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  dmct_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (NUM_LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // counters
  assign upd.en        = done;
  assign upd.hit       = hit;
  assign upd.mem_write = mem_write;

  dmct_stats u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .cnt_nxt (cnt_nxt)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.hit          <= hit;
      out_data_r.line_fetch   <= !hit;
      out_data_r.memory_write <= mem_write;
      out_data_r.hit_count    <= cnt_nxt.hits;
      out_data_r.miss_count   <= cnt_nxt.misses;
      out_data_r.fetch_count  <= cnt_nxt.fetches;
      out_data_r.store_count  <= cnt_nxt.stores;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOKUP))
    else $error("result item appeared without a lookup");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE))
    else $error("line ram written while idle");

  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result item during clearing pass");

  a_lookup_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP && out_valid_r && out_stall) |=> (state_r == ST_LOOKUP))
    else $error("lookup finished while output slot was occupied");

endmodule
